@@ sv/hor_pkg.sv @@
// ----------------------------------------------------------------------------
// hor_pkg
// types, codes and character tables shared by the hex object record parser
// ----------------------------------------------------------------------------
package hor_pkg;

    localparam logic [7:0] C_OUTSIDE  = 8'hFF;
    localparam logic [7:0] C_PERCENT  = 8'h25;
    localparam logic [7:0] C_TOL_RST  = 8'd2;
    localparam logic [7:0] C_FAIL_MAX = 8'hFF;

    // record type digits
    localparam logic [3:0] T_SYMBOL = 4'd3;
    localparam logic [3:0] T_SPACE  = 4'd5;
    localparam logic [3:0] T_DATA   = 4'd6;
    localparam logic [3:0] T_END    = 4'd8;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE = 3'd2;
    localparam logic [2:0] ST_HEADER   = 3'd3;
    localparam logic [2:0] ST_OUTSIDE  = 3'd4;

    // result queue
    localparam int C_FIFO_DEPTH = 4;
    localparam int C_PTR_W      = $clog2(C_FIFO_DEPTH);
    localparam int C_CNT_W      = $clog2(C_FIFO_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [6:0]  byte_index;
        logic [3:0]  block_type;
        logic [59:0] address;
        logic [6:0]  byte_count;
        logic [2:0]  status;
        logic        accepted;
        logic        last;
    } t_result;

    // results produced by one character, in order
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    // sum table value of a character, outside marks a non-member
    function automatic logic [7:0] hor_table_value(input logic [7:0] c);
        logic [7:0] v;
        v = C_OUTSIDE;
        if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41 + 8'd10;
        else if (c == 8'h24) v = 8'd36;
        else if (c == 8'h25) v = 8'd37;
        else if (c == 8'h5F) v = 8'd39;
        else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd40;
        return v;
    endfunction

    // hex digit value, outside marks a non-digit
    function automatic logic [7:0] hor_hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = C_OUTSIDE;
        if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
        else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
        return v;
    endfunction

    // data bytes a record holds, zero for other types or short records
    function automatic logic [6:0] hor_byte_count(input logic [3:0] blk_type,
                                                   input logic [7:0] blk_len,
                                                   input logic [3:0] addr_digits);
        logic [7:0] need;
        logic [7:0] diff;
        need = {4'd0, addr_digits} + 8'd6;
        diff = blk_len - need;
        if (blk_type != T_DATA || blk_len < need) return 7'd0;
        return diff[7:1];
    endfunction

endpackage

@@ sv/hor_core.sv @@
// ----------------------------------------------------------------------------
// hor_core
// per-character record state and result generation, one pass per transfer
// ----------------------------------------------------------------------------
module hor_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_ch,
    input  logic [7:0]     i_tolerance,
    output hor_pkg::t_push o_push
);
    import hor_pkg::*;

    localparam logic PH_IDLE  = 1'b0;
    localparam logic PH_BLOCK = 1'b1;

    logic        r_phase,       n_phase;
    logic [7:0]  r_char_pos,    n_char_pos;
    logic [7:0]  r_block_len,   n_block_len;
    logic [3:0]  r_type,        n_type;
    logic [7:0]  r_exp_sum,     n_exp_sum;
    logic [7:0]  r_run_sum,     n_run_sum;
    logic        r_bad,         n_bad;
    logic [3:0]  r_addr_digits, n_addr_digits;
    logic [59:0] r_addr_value,  n_addr_value;
    logic [3:0]  r_high_nib,    n_high_nib;
    logic [7:0]  r_fail_count,  n_fail_count;

    logic [7:0]  pos;
    logic [7:0]  tab_v;
    logic [7:0]  hex_v;
    logic [3:0]  hex_d;
    logic [7:0]  first_data;
    logic [7:0]  k;
    logic [6:0]  cnt_r;
    logic        hdr_err;
    logic [2:0]  hdr_status;
    logic        fin;
    logic        emit;
    logic [7:0]  emit_byte;
    logic [6:0]  emit_idx;
    logic [2:0]  fin_status;
    logic        fin_acc;
    t_result     base;
    t_result     data_res;
    t_result     stat_res;

    // decode of the incoming character
    always_comb begin
        pos   = r_char_pos + 8'd1;
        tab_v = hor_table_value(i_ch);
        hex_v = hor_hex_value(i_ch);
        hex_d = (hex_v == C_OUTSIDE) ? 4'd0 : hex_v[3:0];
        cnt_r = hor_byte_count(r_type, r_block_len, r_addr_digits);
        first_data = 8'd7 + {4'd0, r_addr_digits};
        k     = pos - first_data;
    end

    // state update for one character
    always_comb begin
        n_phase       = r_phase;
        n_char_pos    = r_char_pos;
        n_block_len   = r_block_len;
        n_type        = r_type;
        n_exp_sum     = r_exp_sum;
        n_run_sum     = r_run_sum;
        n_bad         = r_bad;
        n_addr_digits = r_addr_digits;
        n_addr_value  = r_addr_value;
        n_high_nib    = r_high_nib;
        hdr_err       = 1'b0;
        hdr_status    = ST_OK;
        fin           = 1'b0;
        emit          = 1'b0;
        emit_byte     = 8'd0;
        emit_idx      = 7'd0;
        if (i_accept) begin
            if (r_phase == PH_IDLE) begin
                // start of a block clears the record
                if (i_ch == C_PERCENT) begin
                    n_phase       = PH_BLOCK;
                    n_char_pos    = 8'd0;
                    n_block_len   = 8'd0;
                    n_type        = 4'd0;
                    n_exp_sum     = 8'd0;
                    n_run_sum     = 8'd0;
                    n_bad         = 1'b0;
                    n_addr_digits = 4'd0;
                    n_addr_value  = 60'd0;
                    n_high_nib    = 4'd0;
                end
            end else begin
                n_char_pos = pos;
                if (pos <= 8'd5) begin
                    // header characters
                    if (hex_v == C_OUTSIDE) begin
                        hdr_err    = 1'b1;
                        hdr_status = ST_HEADER;
                        n_phase    = PH_IDLE;
                    end else begin
                        if (pos <= 8'd3) n_run_sum = r_run_sum + tab_v;
                        case (pos)
                            8'd1: n_block_len = {hex_d, 4'd0};
                            8'd2: n_block_len = {r_block_len[7:4], hex_d};
                            8'd3: n_type      = hex_d;
                            8'd4: n_exp_sum   = {hex_d, 4'd0};
                            8'd5: begin
                                n_exp_sum = {r_exp_sum[7:4], hex_d};
                                if (r_type != T_SYMBOL && r_type != T_SPACE &&
                                    r_type != T_DATA && r_type != T_END) begin
                                    hdr_err    = 1'b1;
                                    hdr_status = ST_BAD_TYPE;
                                    n_phase    = PH_IDLE;
                                end else if (r_block_len <= 8'd5) begin
                                    fin     = 1'b1;
                                    n_phase = PH_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end else begin
                    // body characters
                    if (tab_v == C_OUTSIDE) n_bad = 1'b1;
                    else n_run_sum = r_run_sum + tab_v;
                    if (r_type == T_DATA || r_type == T_END) begin
                        if (pos == 8'd6) begin
                            n_addr_digits = hex_d;
                        end else if (pos < first_data) begin
                            n_addr_value = {r_addr_value[55:0], hex_d};
                        end else if (r_type == T_DATA) begin
                            if (!k[0]) begin
                                n_high_nib = hex_d;
                            end else if (k[7:1] < cnt_r) begin
                                emit      = 1'b1;
                                emit_byte = {r_high_nib, hex_d};
                                emit_idx  = k[7:1];
                            end
                        end
                    end
                    if (pos >= r_block_len) begin
                        fin     = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            end
        end
    end

    // checksum verdict and failure count
    always_comb begin
        n_fail_count = r_fail_count;
        if (n_bad) fin_status = ST_OUTSIDE;
        else if (n_run_sum != n_exp_sum) fin_status = ST_MISMATCH;
        else fin_status = ST_OK;
        fin_acc = (fin_status == ST_OK);
        if (fin && fin_status != ST_OK) begin
            if (r_fail_count != C_FAIL_MAX) n_fail_count = r_fail_count + 8'd1;
            fin_acc = (n_fail_count > i_tolerance);
        end
    end

    // result assembly
    always_comb begin
        base            = '0;
        base.block_type = n_type;
        base.address    = (n_type == T_DATA || n_type == T_END) ? n_addr_value : 60'd0;
        base.byte_count = hor_byte_count(n_type, n_block_len, n_addr_digits);

        data_res            = base;
        data_res.kind       = KIND_DATA;
        data_res.data_byte  = emit_byte;
        data_res.byte_index = emit_idx;

        stat_res      = base;
        stat_res.kind = KIND_STATUS;
        stat_res.last = 1'b1;
        if (hdr_err) begin
            stat_res.status   = hdr_status;
            stat_res.accepted = 1'b0;
        end else begin
            stat_res.status   = fin_status;
            stat_res.accepted = fin_acc;
        end

        o_push = '0;
        if (emit && (fin || hdr_err)) begin
            o_push.num  = 2'd2;
            o_push.res0 = data_res;
            o_push.res1 = stat_res;
        end else if (emit) begin
            o_push.num       = 2'd1;
            o_push.res0      = data_res;
            o_push.res0.last = 1'b1;
        end else if (fin || hdr_err) begin
            o_push.num  = 2'd1;
            o_push.res0 = stat_res;
        end
    end

    // record state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_char_pos    <= 8'd0;
            r_block_len   <= 8'd0;
            r_type        <= 4'd0;
            r_exp_sum     <= 8'd0;
            r_run_sum     <= 8'd0;
            r_bad         <= 1'b0;
            r_addr_digits <= 4'd0;
            r_addr_value  <= 60'd0;
            r_high_nib    <= 4'd0;
            r_fail_count  <= 8'd0;
        end else begin
            r_phase       <= n_phase;
            r_char_pos    <= n_char_pos;
            r_block_len   <= n_block_len;
            r_type        <= n_type;
            r_exp_sum     <= n_exp_sum;
            r_run_sum     <= n_run_sum;
            r_bad         <= n_bad;
            r_addr_digits <= n_addr_digits;
            r_addr_value  <= n_addr_value;
            r_high_nib    <= n_high_nib;
            r_fail_count  <= n_fail_count;
        end
    end

endmodule

@@ sv/hor_result_fifo.sv @@
// ----------------------------------------------------------------------------
// hor_result_fifo
// small result queue taking up to two results per cycle and giving one while the reader does not stall
// ----------------------------------------------------------------------------
module hor_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hor_pkg::t_push   i_push,
    input  logic             i_stall,
    output logic             o_valid,
    output hor_pkg::t_result o_result,
    output logic             o_full
);
    import hor_pkg::*;

    t_result              r_mem [C_FIFO_DEPTH];
    logic [C_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [C_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [C_CNT_W-1:0]   r_count,  n_count;
    logic [C_PTR_W-1:0]   wr_ptr1;
    logic                 pop;

    // head of queue and room for two more results
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign o_full   = (r_count > C_CNT_W'(C_FIFO_DEPTH - 2));
    assign pop      = o_valid && !i_stall;
    assign wr_ptr1  = r_wr_ptr + C_PTR_W'(1);

    // pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr + C_PTR_W'(i_push.num);
        n_rd_ptr = pop ? r_rd_ptr + C_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + C_CNT_W'(i_push.num) - C_CNT_W'(pop);
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) r_mem[r_wr_ptr] <= i_push.res0;
        if (i_push.num == 2'd2) r_mem[wr_ptr1]  <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ sv/hex_object_record_parser.sv @@
// ----------------------------------------------------------------------------
// hex_object_record_parser
// parses extended hex object records one character per transfer
// ----------------------------------------------------------------------------
// results: the core is combinational and its results are registered in the result queue
// throughput: one character per cycle, set by the single-pass state update;
//   an end of record with a data byte gives two results, drained from a
//   four-entry result queue that stalls input while it holds more than two
// reset: synchronous active low, parser idle, failure count zero,
//   error tolerance 2, queue empty
module hex_object_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [6:0]  o_byte_index,
    output logic [3:0]  o_block_type,
    output logic [59:0] o_address,
    output logic [6:0]  o_byte_count,
    output logic [2:0]  o_status,
    output logic        o_accepted,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_error_tolerance
);
    import hor_pkg::*;

    logic [7:0] r_error_tolerance;
    logic       in_accept;
    t_push      push;
    t_result    head;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_tolerance <= C_TOL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_error_tolerance <= i_cfg_error_tolerance;
        end
    end

    hor_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_ch        (i_ch),
        .i_tolerance (r_error_tolerance),
        .o_push      (push)
    );

    hor_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (head),
        .o_full   (o_in_stall)
    );

    // result fields
    assign o_kind       = head.kind;
    assign o_data_byte  = head.data_byte;
    assign o_byte_index = head.byte_index;
    assign o_block_type = head.block_type;
    assign o_address    = head.address;
    assign o_byte_count = head.byte_count;
    assign o_status     = head.status;
    assign o_accepted   = head.accepted;
    assign o_last       = head.last;

    // checks
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.num == 2'd2 |-> push.res0.kind == KIND_DATA && push.res1.kind == KIND_STATUS
                             && !push.res0.last && push.res1.last)
        else $error("two results not ordered data then status");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |-> push.num == 2'd0)
        else $error("result produced without an input transfer");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DATA |-> o_status == ST_OK && !o_accepted)
        else $error("data byte result carries status");

    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("queue not empty after reset");

endmodule

@@ dv/hex_object_record_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_object_record_parser_test
// feeds record streams through the parser and checks every result against a
// cycle-free model of the record state machine; both sides idle at random,
// and the error tolerance is changed between runs of traffic
// ----------------------------------------------------------------------------
module hex_object_record_parser_test;
    import hor_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // kinds of damage put into a generated record
    typedef enum {
        F_NONE,
        F_SUM,
        F_OUTSIDE,
        F_BODY_NONHEX,
        F_HDR_NONHEX,
        F_PERCENT,
        F_SHORT,
        F_LEN
    } t_flaw;

    logic        i_clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [7:0]  in_ch         = 8'd0;
    logic        out_stall     = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic [7:0]  cfg_tolerance = 8'd0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [6:0]  o_byte_index;
    logic [3:0]  o_block_type;
    logic [59:0] o_address;
    logic [6:0]  o_byte_count;
    logic [2:0]  o_status;
    logic        o_accepted;
    logic        o_last;
    logic        o_cfg_ready;

    // traffic shaping
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          lower_pct     = 25;
    int          stream_chars  = 0;
    int          errors        = 0;
    int          quiet         = 0;

    logic [7:0]  char_backlog [$];
    t_result     results_due [$];
    t_result     want;

    // parser model state
    logic        rec_open     = 1'b0;
    logic [7:0]  rec_pos      = 8'd0;
    logic [7:0]  rec_len      = 8'd0;
    logic [3:0]  rec_type     = 4'd0;
    logic [7:0]  rec_sum_want = 8'd0;
    logic [7:0]  rec_sum      = 8'd0;
    logic        rec_bad      = 1'b0;
    logic [3:0]  rec_addr_len = 4'd0;
    logic [59:0] rec_addr     = 60'd0;
    logic [3:0]  rec_high     = 4'd0;
    logic [7:0]  fail_count   = 8'd0;
    logic [7:0]  tolerance    = C_TOL_RST;

    hex_object_record_parser dut (
        .i_clk                 (i_clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (o_in_stall),
        .i_ch                  (in_ch),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (out_stall),
        .o_kind                (o_kind),
        .o_data_byte           (o_data_byte),
        .o_byte_index          (o_byte_index),
        .o_block_type          (o_block_type),
        .o_address             (o_address),
        .o_byte_count          (o_byte_count),
        .o_status              (o_status),
        .o_accepted            (o_accepted),
        .o_last                (o_last),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_error_tolerance (cfg_tolerance)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // checksum weight of a character, outside marks a non-member
    function automatic logic [7:0] char_weight(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h41 && c <= 8'h5A) return c - 8'h41 + 8'd10;
        if (c == 8'h24) return 8'd36;
        if (c == C_PERCENT) return 8'd37;
        if (c == 8'h5F) return 8'd39;
        if (c >= 8'h61 && c <= 8'h7A) return c - 8'h61 + 8'd40;
        return C_OUTSIDE;
    endfunction

    // value of a hex digit in either case
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 8'd10;
        if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 8'd10;
        return C_OUTSIDE;
    endfunction

    // data bytes the current record can carry
    function automatic logic [6:0] bytes_in_record();
        int need;
        need = int'(rec_addr_len) + 6;
        if (rec_type != T_DATA || int'(rec_len) < need) return 7'd0;
        return 7'((int'(rec_len) - need) >> 1);
    endfunction

    function automatic t_result make_result(input logic kind, input logic [7:0] dbyte,
                                            input logic [6:0] idx, input logic [2:0] st,
                                            input logic acc);
        t_result r;
        r.kind       = kind;
        r.data_byte  = dbyte;
        r.byte_index = idx;
        r.block_type = rec_type;
        r.address    = (rec_type == T_DATA || rec_type == T_END) ? rec_addr : 60'd0;
        r.byte_count = bytes_in_record();
        r.status     = st;
        r.accepted   = acc;
        r.last       = 1'b0;
        return r;
    endfunction

    // advance the model by one character and queue what it emits
    task automatic parse_char(input logic [7:0] c);
        logic [7:0] v;
        logic [7:0] h;
        logic [2:0] st;
        logic       acc;
        logic       closing;
        int         first;
        int         k;
        int         n;
        t_result    res [2];
        n       = 0;
        closing = 1'b0;
        if (!rec_open) begin
            if (c == C_PERCENT) begin
                rec_open     = 1'b1;
                rec_pos      = 8'd0;
                rec_len      = 8'd0;
                rec_type     = 4'd0;
                rec_sum_want = 8'd0;
                rec_sum      = 8'd0;
                rec_bad      = 1'b0;
                rec_addr_len = 4'd0;
                rec_addr     = 60'd0;
                rec_high     = 4'd0;
            end
        end else begin
            rec_pos = rec_pos + 8'd1;
            v = char_weight(c);
            h = digit_value(c);
            if (rec_pos <= 8'd5) begin
                // header: any non-hex character aborts the record
                if (h == C_OUTSIDE) begin
                    res[n] = make_result(KIND_STATUS, 8'd0, 7'd0, ST_HEADER, 1'b0);
                    n++;
                    rec_open = 1'b0;
                end else begin
                    if (rec_pos <= 8'd3) rec_sum = rec_sum + v;
                    case (rec_pos)
                        8'd1: rec_len = {h[3:0], 4'h0};
                        8'd2: rec_len[3:0] = h[3:0];
                        8'd3: rec_type = h[3:0];
                        8'd4: rec_sum_want = {h[3:0], 4'h0};
                        default: begin
                            rec_sum_want[3:0] = h[3:0];
                            if (!(rec_type inside {T_SYMBOL, T_SPACE, T_DATA, T_END})) begin
                                res[n] = make_result(KIND_STATUS, 8'd0, 7'd0, ST_BAD_TYPE,
                                                     1'b0);
                                n++;
                                rec_open = 1'b0;
                            end else if (rec_len <= 8'd5) begin
                                closing = 1'b1;
                            end
                        end
                    endcase
                end
            end else begin
                // body: summed, non-hex digits read as zero
                if (v == C_OUTSIDE) rec_bad = 1'b1;
                else rec_sum = rec_sum + v;
                if (h == C_OUTSIDE) h = 8'd0;
                if (rec_type == T_DATA || rec_type == T_END) begin
                    first = 7 + int'(rec_addr_len);
                    if (rec_pos == 8'd6) begin
                        rec_addr_len = h[3:0];
                    end else if (int'(rec_pos) < first) begin
                        rec_addr = {rec_addr[55:0], h[3:0]};
                    end else if (rec_type == T_DATA) begin
                        k = int'(rec_pos) - first;
                        if (k % 2 == 0) begin
                            rec_high = h[3:0];
                        end else if ((k >> 1) < int'(bytes_in_record())) begin
                            res[n] = make_result(KIND_DATA, {rec_high, h[3:0]}, 7'(k >> 1),
                                                 ST_OK, 1'b0);
                            n++;
                        end
                    end
                end
                if (rec_pos >= rec_len) closing = 1'b1;
            end
            // end of block status
            if (closing) begin
                st  = rec_bad ? ST_OUTSIDE : (rec_sum != rec_sum_want ? ST_MISMATCH : ST_OK);
                acc = (st == ST_OK);
                if (st != ST_OK) begin
                    if (fail_count != C_FAIL_MAX) fail_count = fail_count + 8'd1;
                    if (fail_count > tolerance) acc = 1'b1;
                end
                res[n] = make_result(KIND_STATUS, 8'd0, 7'd0, st, acc);
                n++;
                rec_open = 1'b0;
            end
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) results_due.push_back(res[i]);
    endtask

    // ascii hex digit, letters in random case
    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'h30 + 8'(v);
        if ($urandom_range(99) < lower_pct) return 8'h61 + 8'(v - 10);
        return 8'h41 + 8'(v - 10);
    endfunction

    function automatic logic [7:0] fill_digit(input int fill);
        return hex_char(fill < 0 ? int'($urandom_range(15)) : fill);
    endfunction

    // random member of the character set other than percent
    function automatic logic [7:0] set_char();
        int pick;
        pick = $urandom_range(63);
        if (pick < 10) return 8'h30 + 8'(pick);
        if (pick < 36) return 8'h41 + 8'(pick - 10);
        if (pick < 62) return 8'h61 + 8'(pick - 36);
        if (pick == 62) return 8'h24;
        return 8'h5F;
    endfunction

    // one record with optional damage, followed by a little idle noise
    task automatic put_record(input logic [3:0] rtype, input int alen, input int nbytes,
                              input int extra, input t_flaw flaw, input int fill);
        logic [7:0] body [$];
        logic [7:0] head [5];
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] c;
        int         at;
        body = {};
        if (flaw != F_SHORT) begin
            if (rtype == T_DATA || rtype == T_END) begin
                body.push_back(hex_char(alen));
                repeat (alen) body.push_back(fill_digit(fill));
                if (rtype == T_DATA) repeat (2 * nbytes) body.push_back(fill_digit(fill));
                repeat (extra) body.push_back(set_char());
            end else begin
                repeat (2 * nbytes + extra) body.push_back(set_char());
            end
        end
        if (body.size() > 0) begin
            at = $urandom_range(body.size() - 1);
            case (flaw)
                F_OUTSIDE: begin
                    do c = 8'($urandom_range(255)); while (char_weight(c) != C_OUTSIDE);
                    body[at] = c;
                end
                F_BODY_NONHEX: begin
                    do c = set_char(); while (digit_value(c) != C_OUTSIDE);
                    body[at] = c;
                end
                F_PERCENT: body[at] = C_PERCENT;
                default: ;
            endcase
        end
        if (flaw == F_SHORT) len = 8'($urandom_range(5));
        else if (flaw == F_LEN) len = 8'($urandom_range(255));
        else len = 8'(5 + body.size());
        head[0] = hex_char(len[7:4]);
        head[1] = hex_char(len[3:0]);
        head[2] = hex_char(rtype);
        sum = char_weight(head[0]) + char_weight(head[1]) + char_weight(head[2]);
        foreach (body[i]) begin
            if (char_weight(body[i]) != C_OUTSIDE) sum = sum + char_weight(body[i]);
        end
        if (flaw == F_SUM) sum = sum + 8'($urandom_range(1, 255));
        head[3] = hex_char(sum[7:4]);
        head[4] = hex_char(sum[3:0]);
        if (flaw == F_HDR_NONHEX) begin
            do c = 8'($urandom_range(255)); while (digit_value(c) != C_OUTSIDE);
            head[$urandom_range(4)] = c;
        end
        char_backlog.push_back(C_PERCENT);
        foreach (head[i]) char_backlog.push_back(head[i]);
        foreach (body[i]) char_backlog.push_back(body[i]);
        stream_chars += 6 + body.size();
        repeat ($urandom_range(2)) begin
            do c = 8'($urandom_range(255)); while (c == C_PERCENT);
            char_backlog.push_back(c);
        end
    endtask

    function automatic logic [3:0] valid_type();
        case ($urandom_range(3))
            0: return T_SYMBOL;
            1: return T_SPACE;
            2: return T_DATA;
            default: return T_END;
        endcase
    endfunction

    // mostly well-formed records of small size, the rest damaged
    task automatic random_record();
        int         pick;
        int         alen;
        int         nbytes;
        int         extra;
        logic [3:0] rtype;
        t_flaw      flaw;
        pick   = $urandom_range(99);
        alen   = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(4);
        nbytes = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(4);
        extra  = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
        rtype  = valid_type();
        flaw   = F_NONE;
        if (pick < 55) rtype = T_DATA;
        else if (pick < 64) rtype = T_END;
        else if (pick < 70) rtype = ($urandom_range(1) != 0) ? T_SYMBOL : T_SPACE;
        else if (pick < 77) flaw = F_SUM;
        else if (pick < 82) flaw = F_OUTSIDE;
        else if (pick < 86) flaw = F_BODY_NONHEX;
        else if (pick < 90) flaw = F_HDR_NONHEX;
        else if (pick < 92) flaw = F_PERCENT;
        else if (pick < 95) begin
            do rtype = 4'($urandom_range(15));
            while (rtype inside {T_SYMBOL, T_SPACE, T_DATA, T_END});
        end
        else if (pick < 98) flaw = F_SHORT;
        else flaw = F_LEN;
        put_record(rtype, alen, nbytes, extra, flaw, -1);
    endtask

    task automatic random_stream(input int chars);
        int goal;
        goal = stream_chars + chars;
        while (stream_chars < goal) random_record();
    endtask

    // wait until the block holds nothing, plus its latency
    task automatic drain();
        while (char_backlog.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [7:0] value);
        cfg_valid     <= 1'b1;
        cfg_tolerance <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        tolerance = value;
    endtask

    task automatic check_field(input string name, input logic [59:0] exp_val,
                               input logic [59:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            errors++;
        end
    endtask

    // character driver, predicts each character on its transfer
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) parse_char(in_ch);
            if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_ch    <= char_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte", want.data_byte, o_data_byte);
                    check_field("byte_index", want.byte_index, o_byte_index);
                    check_field("block_type", want.block_type, o_block_type);
                    check_field("address", want.address, o_address);
                    check_field("byte_count", want.byte_count, o_byte_count);
                    check_field("status", want.status, o_status);
                    check_field("accepted", want.accepted, o_accepted);
                    check_field("last", want.last, o_last);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_idle_pct = 88;

        // directed records at the reset tolerance
        put_record(T_DATA, 4, 3, 0, F_NONE, -1);
        put_record(T_DATA, 0, 2, 0, F_NONE, 0);       // zero address length, zero bytes
        put_record(T_END, 15, 0, 0, F_NONE, 15);      // widest address
        put_record(T_DATA, 1, 124, 0, F_NONE, 15);    // longest block, all ff bytes
        put_record(T_SYMBOL, 0, 4, 1, F_NONE, -1);
        put_record(T_SPACE, 0, 0, 0, F_NONE, -1);     // header only
        put_record(T_DATA, 2, 3, 1, F_NONE, -1);      // trailing odd digit
        put_record(T_DATA, 2, 2, 3, F_NONE, -1);      // surplus characters
        lower_pct = 100;
        put_record(T_DATA, 3, 6, 0, F_NONE, -1);      // lower case hex throughout
        lower_pct = 25;
        put_record(T_DATA, 3, 4, 0, F_BODY_NONHEX, -1);
        repeat (4) put_record(T_DATA, 2, 2, 0, F_SUM, -1);  // failures past tolerance
        put_record(T_SYMBOL, 0, 3, 0, F_OUTSIDE, -1);
        put_record(T_SPACE, 0, 3, 0, F_PERCENT, -1);  // percent inside the block
        put_record(T_DATA, 2, 2, 0, F_HDR_NONHEX, -1);
        char_backlog.push_back(C_PERCENT);             // percent as a header character
        char_backlog.push_back(C_PERCENT);
        put_record(4'h0, 0, 1, 0, F_NONE, -1);        // bad type digits
        put_record(4'hF, 0, 1, 0, F_NONE, -1);
        put_record(T_DATA, 0, 0, 0, F_SHORT, -1);
        put_record(T_SYMBOL, 0, 0, 0, F_SHORT, -1);
        char_backlog.push_back(8'h00);
        char_backlog.push_back(8'hFF);
        random_stream(270);
        drain();

        for (int ph = 1; ph < 5; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 36;
                recv_idle_pct = 88;
            end else if (ph < 4) begin
                send_idle_pct = 88;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: write_tolerance(8'd0);
                2: write_tolerance(8'd255);
                3: write_tolerance(8'($urandom_range(1, 254)));
                default: write_tolerance(8'd1);
            endcase
            random_stream(270);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/hor_pkg.sv
sv/hor_core.sv
sv/hor_result_fifo.sv
sv/hex_object_record_parser.sv
dv/hex_object_record_parser_test.sv
